// File: src/swa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants and controller/datapath interface types for the
// sliding window averager.
// ----------------------------------------------------------------------------
package swa_pkg;

	localparam int DEPTH     = 64;                  // sample slots
	localparam int AW        = $clog2(DEPTH);       // slot address
	localparam int CNT_W     = $clog2(DEPTH + 1);   // counts 0..DEPTH
	localparam int CFG_W     = 7;                   // register data width
	localparam int CFG_IDX_W = 2;
	localparam int SMP_W     = 16;
	localparam int SUM_W     = SMP_W + AW;          // exact window sum
	localparam int DIV_STEPS = SUM_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
	localparam int OUT_W     = 32;                  // result tdata, byte padded

	localparam logic [CFG_IDX_W-1:0] REG_BUF_LEN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = CFG_IDX_W'(1);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic load;        // capture input beat
		logic update;      // write sample / clear, move pointer and count
		logic sum_start;   // set up window read
		logic sum_step;    // one read and accumulate
		logic div_start;   // load divider
		logic div_step;    // one quotient bit
		logic out_load;    // load result register
	} swa_cmd_t;

	typedef struct packed {
		logic sum_done;
		logic div_done;
	} swa_status_t;

endpackage

// File: src/int16_sliding_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int16_sliding_window_average
// Moving average of signed 16-bit samples over a configurable window.
// ----------------------------------------------------------------------------
// Each input beat (tuser = op: push or clear, tdata = sample) yields one
// result beat. Items are handled one at a time: a beat runs a serial read
// of its window, w samples where w is the number of samples averaged (up to
// 64), from the sample store (one sample per cycle), then a 22-step
// restoring divide. The next beat is accepted
// while a finished result still waits on the output. Configuration writes
// are always accepted and must only be made while the block is idle;
// writing buffer_length empties the store.
module int16_sliding_window_average (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] sample
	input  logic [0:0]                    s_tuser,   // [0] op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] average, [22:16] fill_count, [23] is_empty, [24] is_full, rest zero
	output logic [swa_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [swa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swa_pkg::CFG_W-1:0]     cfg_data
);
	import swa_pkg::*;

	swa_cmd_t    cmd;
	swa_status_t status;

	assign cfg_ready = 1'b1;

	swa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	swa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.in_op     (s_tuser[0]),
		.in_sample (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

// File: src/swa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_ctrl
// Sequencer: walks one beat through store update, window sum, divide and
// result load; owns the result valid flag.
// ----------------------------------------------------------------------------
module swa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  swa_pkg::swa_status_t status,
	output swa_pkg::swa_cmd_t    cmd
);
	import swa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_PREP,
		ST_SUM,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load      = in_valid;
			ST_UPDATE:   cmd.update    = 1'b1;
			ST_PREP:     cmd.sum_start = 1'b1;
			ST_SUM:      cmd.sum_step  = 1'b1;
			ST_DIV_INIT: cmd.div_start = 1'b1;
			ST_DIV:      cmd.div_step  = !status.div_done;
			ST_OUT:      cmd.out_load  = out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken in the same cycle
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:     if (in_valid) state_q <= ST_UPDATE;
				ST_UPDATE:   state_q <= ST_PREP;
				ST_PREP:     state_q <= ST_SUM;
				ST_SUM:      if (status.sum_done) state_q <= ST_DIV_INIT;
				ST_DIV_INIT: state_q <= ST_DIV;
				ST_DIV:      if (status.div_done) state_q <= ST_OUT;
				ST_OUT:      if (out_free) state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/swa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_dp
// Datapath: configuration registers, circular sample store, serial window
// accumulator, restoring divider and result register.
// ----------------------------------------------------------------------------
module swa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swa_pkg::swa_cmd_t              cmd,
	output swa_pkg::swa_status_t           status,
	input  logic                           cfg_we,
	input  logic [swa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [swa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_op,
	input  logic [swa_pkg::SMP_W-1:0]      in_sample,
	output logic [swa_pkg::OUT_W-1:0]      out_data
);
	import swa_pkg::*;

	localparam int REM_W = CNT_W;

	// configuration and store state
	logic [CFG_W-1:0] buf_len_q, win_len_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] held_q;
	logic [SMP_W-1:0] mem [DEPTH];

	// captured beat
	logic             op_q;
	logic [SMP_W-1:0] smp_q;

	// window read
	logic [AW-1:0]          rd_idx_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic [CNT_W-1:0]       w_q;
	logic                   rd_vld_s1;
	logic [SMP_W-1:0]       rd_data_s1;
	logic signed [SUM_W-1:0] acc_q;

	// divider
	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              neg_q;

	logic [OUT_W-1:0] out_q;

	logic [CNT_W-1:0] eff_len, eff_win, win_w, wp_next;
	logic [SUM_W-1:0] acc_mag, quo_signed;
	logic [REM_W:0]   rem_sh, trial;
	logic [SMP_W-1:0] avg;

	always_comb begin
		if (buf_len_q == '0)
			eff_len = CNT_W'(1);
		else if (buf_len_q > CFG_W'(DEPTH))
			eff_len = CNT_W'(DEPTH);
		else
			eff_len = CNT_W'(buf_len_q);

		if (win_len_q == '0)
			eff_win = CNT_W'(1);
		else if (CNT_W'(win_len_q) > eff_len || win_len_q > CFG_W'(DEPTH))
			eff_win = eff_len;
		else
			eff_win = CNT_W'(win_len_q);

		win_w   = (eff_win > held_q) ? held_q : eff_win;
		wp_next = CNT_W'(wp_q) + CNT_W'(1);
	end

	assign acc_mag    = acc_q[SUM_W-1] ? SUM_W'(~acc_q + 1'b1) : SUM_W'(acc_q);
	assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
	assign trial      = rem_sh - {1'b0, w_q};
	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign avg        = (w_q == '0) ? '0 : quo_signed[SMP_W-1:0];

	assign status.sum_done = (rd_cnt_q == '0) && !rd_vld_s1;
	assign status.div_done = (div_cnt_q == '0);
	assign out_data        = out_q;

	// control state of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= CFG_W'(DEPTH);
			win_len_q <= CFG_W'(64);
			wp_q      <= '0;
			held_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_cnt_q  <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_idx == REG_BUF_LEN) begin
				buf_len_q <= cfg_wdata;
				wp_q      <= '0;   // new length starts a fresh store
				held_q    <= '0;
			end
			if (cfg_we && cfg_idx == REG_WIN_LEN)
				win_len_q <= cfg_wdata;

			if (cmd.update) begin
				if (op_q == OP_CLEAR) begin
					wp_q   <= '0;
					held_q <= '0;
				end else begin
					wp_q <= (wp_next == eff_len) ? '0 : wp_q + 1'b1;
					if (held_q < eff_len)
						held_q <= held_q + 1'b1;
				end
			end

			rd_vld_s1 <= cmd.sum_step && (rd_cnt_q != '0);
			if (cmd.sum_start)
				rd_cnt_q <= win_w;
			else if (cmd.sum_step && rd_cnt_q != '0)
				rd_cnt_q <= rd_cnt_q - 1'b1;

			if (cmd.div_start)
				div_cnt_q <= DCNT_W'(DIV_STEPS);
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.update && op_q == OP_PUSH)
			mem[wp_q] <= smp_q;
		rd_data_s1 <= mem[rd_idx_q];
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			smp_q <= in_sample;
		end

		if (cmd.sum_start) begin
			w_q      <= win_w;
			acc_q    <= '0;
			rd_idx_q <= (wp_q == '0) ? AW'(eff_len - 1'b1) : wp_q - 1'b1;
		end else begin
			if (cmd.sum_step && rd_cnt_q != '0)
				rd_idx_q <= (rd_idx_q == '0) ? AW'(eff_len - 1'b1) : rd_idx_q - 1'b1;
			if (rd_vld_s1)
				acc_q <= acc_q + {{(SUM_W-SMP_W){rd_data_s1[SMP_W-1]}}, rd_data_s1};
		end

		if (cmd.div_start) begin
			neg_q <= acc_q[SUM_W-1];
			quo_q <= acc_mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[REM_W]) begin
				rem_q <= trial[REM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[REM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end

		if (cmd.out_load)
			out_q <= {(OUT_W-SMP_W-CNT_W-2)'(0), (held_q == eff_len), (held_q == '0),
				held_q, avg};
	end

endmodule

// File: src/swa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks for the sliding window averager, bound to the top level.
// ----------------------------------------------------------------------------
module swa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [6:0]  cfg_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one item in flight: input closes after each accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted back to back");

	// empty flag agrees with the fill count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23] == (m_tdata[22:16] == 7'd0)))
		else $error("is_empty does not match fill_count");

	// empty store reports zero average and not full
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> m_tdata[15:0] == 16'd0 && !m_tdata[24])
		else $error("empty store with non-zero average or full flag");

	// fill count within store depth, padding zero
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:16] <= 7'd64 && m_tdata[31:25] == 7'd0)
		else $error("fill_count out of range or padding set");

endmodule

bind int16_sliding_window_average swa_checker u_swa_checker (.*);

// File: bench/int16_sliding_window_average_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int16_sliding_window_average_test
// Self-checking bench for the sliding window averager. A predictor keeps its
// own copy of the sample store, pointer, count and length registers and works
// out the result beat for every accepted input beat. Stimulus runs in phases
// under different buffer and window lengths, zero and oversized among them,
// with random idle bursts on both stream sides in most of them.
// ----------------------------------------------------------------------------
module int16_sliding_window_average_test;

	import swa_pkg::*;

	typedef struct packed {
		logic             op;
		logic [SMP_W-1:0] sample;
	} sample_beat_t;

	typedef struct packed {
		logic                    is_full;
		logic                    is_empty;
		logic [6:0]              fill_count;
		logic signed [SMP_W-1:0] average;
	} window_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int16_sliding_window_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// predictor state, reset values
	logic signed [SMP_W-1:0] sample_slots [DEPTH];
	int                      wr_slot      = 0;
	int                      held_samples = 0;
	logic [CFG_W-1:0]        slot_cfg     = CFG_W'(DEPTH);
	logic [CFG_W-1:0]        win_cfg      = CFG_W'(64);

	sample_beat_t   pending_beats [$];
	window_result_t averages_due  [$];
	bit             beat_taken    = 1'b0;
	int             gap_left      = 0;
	int             stall_left    = 0;
	int             src_idle_pct  = 0;
	int             sink_idle_pct = 0;
	int             fault_count   = 0;

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == REG_BUF_LEN) begin
			slot_cfg     = val;
			wr_slot      = 0;
			held_samples = 0;
		end else if (idx == REG_WIN_LEN) begin
			win_cfg = val;
		end
	endfunction

	function automatic window_result_t window_step(logic op, logic [SMP_W-1:0] smp);
		int             len;
		int             w;
		int             sum;
		int             idx;
		window_result_t r;
		len = (slot_cfg == 0) ? 1 : (slot_cfg > DEPTH) ? DEPTH : int'(slot_cfg);
		if (wr_slot >= len)
			wr_slot = 0;
		if (held_samples > len)
			held_samples = len;
		if (op == OP_CLEAR) begin
			wr_slot      = 0;
			held_samples = 0;
		end else begin
			sample_slots[wr_slot] = smp;
			wr_slot = (wr_slot + 1) % len;
			if (held_samples < len)
				held_samples++;
		end
		sum = 0;
		w   = 1;
		if (held_samples != 0) begin
			w = (win_cfg == 0) ? 1 : int'(win_cfg);
			if (w > len)
				w = len;
			if (w > held_samples)
				w = held_samples;
			// newest first, walking back from the write slot
			for (int i = 0; i < w; i++) begin
				idx = (wr_slot + len - 1 - i) % len;
				sum += sample_slots[idx];
			end
		end
		r.average    = (held_samples == 0) ? '0 : SMP_W'(sum / w);
		r.fill_count = 7'(held_samples);
		r.is_empty   = (held_samples == 0);
		r.is_full    = (held_samples == len);
		return r;
	endfunction

	task automatic report_fault(string msg);
		if (fault_count < 10)
			$display("%0t: %s", $realtime, msg);
		fault_count++;
	endtask

	// rising edge: register writes, result check, input capture
	always @(posedge clk) begin : score
		window_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready) begin
				if (averages_due.size() == 0) begin
					report_fault($sformatf("result beat %h with no item outstanding", m_tdata));
				end else begin
					want = averages_due.pop_front();
					if (m_tdata[15:0] !== want.average || m_tdata[22:16] !== want.fill_count ||
					    m_tdata[23] !== want.is_empty || m_tdata[24] !== want.is_full ||
					    m_tdata[OUT_W-1:25] !== '0)
						// expected/actual pairs
						report_fault($sformatf(
							"avg %0d/%0d fill %0d/%0d empty %b/%b full %b/%b pad %h",
							want.average, $signed(m_tdata[15:0]),
							want.fill_count, m_tdata[22:16],
							want.is_empty, m_tdata[23], want.is_full, m_tdata[24],
							m_tdata[OUT_W-1:25]));
				end
			end
			if (s_tvalid && s_tready) begin
				beat_taken = 1'b1;
				averages_due.push_back(window_step(s_tuser[0], s_tdata));
			end
		end
	end

	// source side
	always @(negedge clk) begin : source
		sample_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !beat_taken) begin
			// hold the beat
		end else begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
				gap_left = $urandom_range(0, 18);
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				nxt = pending_beats.pop_front();
				s_tdata  <= nxt.sample;
				s_tuser  <= nxt.op;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			stall_left = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// waits until every queued beat is sent and every result is back
	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (pending_beats.size() != 0 || averages_due.size() != 0 ||
		       (s_tvalid && !beat_taken)) begin
			@(posedge clk);
			#1;
		end
	endtask

	task automatic push_beat(logic op, logic [SMP_W-1:0] smp);
		pending_beats.push_back('{op: op, sample: smp});
	endtask

	// mode 0: mixed, 1: mostly most negative, 2: mostly most positive
	function automatic sample_beat_t random_beat(int mode);
		sample_beat_t b;
		b.op = ($urandom_range(0, 31) == 0) ? OP_CLEAR : OP_PUSH;
		case (mode)
			1: b.sample = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h8000;
			2: b.sample = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h7fff;
			default: begin
				case ($urandom_range(0, 9))
					0:       b.sample = 16'h7fff;
					1:       b.sample = 16'h8000;
					2:       b.sample = 16'($urandom_range(0, 16)) - 16'd8;
					default: b.sample = 16'($urandom);
				endcase
			end
		endcase
		return b;
	endfunction

	// negative length skips that write; a buffer length write also empties the store
	task automatic run_phase(int buf_val, int win_val, int n_items, int mode, bit idle_on);
		if (!idle_on) begin
			// no leftover burst from the previous phase
			gap_left   = 0;
			stall_left = 0;
		end
		if (buf_val >= 0)
			write_reg(REG_BUF_LEN, CFG_W'(buf_val));
		if (win_val >= 0)
			write_reg(REG_WIN_LEN, CFG_W'(win_val));
		src_idle_pct  = idle_on ? $urandom_range(0, 40) : 0;
		sink_idle_pct = idle_on ? $urandom_range(0, 40) : 0;
		repeat (n_items)
			pending_beats.push_back(random_beat(mode));
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset lengths: clear on empty, extremes, truncation toward zero
		src_idle_pct  = 20;
		sink_idle_pct = 20;
		push_beat(OP_CLEAR, 16'h0000);
		push_beat(OP_PUSH,  16'h7fff);
		push_beat(OP_PUSH,  16'h8000);
		push_beat(OP_PUSH,  16'hffff);
		push_beat(OP_PUSH,  16'h8000);
		push_beat(OP_PUSH,  16'h0001);
		push_beat(OP_PUSH,  16'h0000);
		push_beat(OP_PUSH,  16'h8001);
		push_beat(OP_PUSH,  16'h7ffe);
		push_beat(OP_CLEAR, 16'hffff);
		push_beat(OP_CLEAR, 16'h7fff);
		push_beat(OP_PUSH,  16'h5555);
		push_beat(OP_PUSH,  16'haaaa);
		push_beat(OP_PUSH,  16'hfffd);
		push_beat(OP_PUSH,  16'h0002);
		push_beat(OP_PUSH,  16'hfffe);
		push_beat(OP_CLEAR, 16'h8000);
		push_beat(OP_PUSH,  16'hfffb);
		push_beat(OP_PUSH,  16'h0003);
		wait_drained();

		run_phase(1,   1,   60,  0, 1'b1);
		run_phase(0,   0,   60,  0, 1'b1);
		run_phase(127, 127, 150, 1, 1'b1);
		run_phase(-1,  1,   40,  0, 1'b1);
		run_phase(2,   1,   60,  0, 1'b1);
		run_phase(5,   9,   80,  0, 1'b1);
		run_phase(4,   2,   60,  2, 1'b1);
		run_phase(17,  64,  80,  0, 1'b1);
		run_phase(64,  1,   60,  0, 1'b1);
		run_phase(33,  0,   80,  0, 1'b1);
		run_phase(64,  100, 150, 2, 1'b1);
		run_phase(-1,  37,  60,  0, 1'b1);
		run_phase(64,  64,  80,  0, 1'b0);
		run_phase(7,   3,   60,  0, 1'b0);

		repeat (100) @(posedge clk);
		#1;
		if (fault_count == 0 && averages_due.size() == 0)
			$display("int16_sliding_window_average_test passed");
		else
			$display("int16_sliding_window_average_test failed");
		$finish;
	end

	initial begin
		#6000000;
		$display("int16_sliding_window_average_test failed");
		$finish;
	end

endmodule
